[design/bis_pkg.sv]
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and codes for the box IoU suppression pipeline.
// ----------------------------------------------------------------------------
package bis_pkg;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MODE      = 1'b1;

    // threshold register
    localparam int THR_BITS = 16;
    localparam logic [THR_BITS-1:0] THR_RESET = 16'h8000;

    // item kinds on the input tuser bit
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPARE = 1'b1;

    // decision flags that follow a compare item down the pipeline
    typedef struct packed {
        logic cvalid;   // candidate valid on entry
        logic cmatch;   // class equals reference class
        logic zero;     // no overlap on some axis
        logic sat;      // union not above intersection
    } side_t;

endpackage

[design/box_iou_suppress_top.sv]
// pipeline: 5 front stages + IOU_FRAC_BITS divider stages + 1 output stage
//   from input item to result item
// throughput: one item per cycle unless the output stalls, with the one-bit-per-stage divider pipe
// load items give no result and leave the pipeline after stage two
// reset: asynchronous active low, clears valid bits, reference box and
//   registers (threshold 0x8000, 2D mode); no clearing pass
// ----------------------------------------------------------------------------
// box_iou_suppress_top
// Pairwise IoU and class-aware suppression step of non-maximum suppression.
// ----------------------------------------------------------------------------
module box_iou_suppress_top #(
    parameter int COORD_BITS    = 16,
    parameter int CLASS_BITS    = 8,
    parameter int IOU_FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // fields: pos_x, pos_y, pos_z, size_w, size_d, size_h, class_label,
    //         candidate_valid, zero fill
    input  logic [((6*COORD_BITS+CLASS_BITS+1+7)/8)*8-1:0] s_tdata,
    // fields: action
    input  logic                              s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // fields: iou_value, valid_out, suppressed, zero fill
    output logic [((IOU_FRAC_BITS+2+7)/8)*8-1:0] m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_we,
    input  logic [bis_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [bis_pkg::THR_BITS-1:0]      cfg_data
);
    import bis_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int CL  = CLASS_BITS;
    localparam int F   = IOU_FRAC_BITS;
    localparam int SW  = 3 * C + 4;
    localparam int OTW = ((F + 2 + 7) / 8) * 8;
    localparam int CW  = 32;

    // configuration registers
    logic [THR_BITS-1:0] thr_reg;
    logic                mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD: thr_reg  <= cfg_data;
                REG_MODE:      mode_reg <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // front pipeline
    logic          f_valid, f_ready;
    logic [SW-1:0] f_rem, f_uni;
    side_t         f_side;

    bis_front #(.C(C), .CL(CL)) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .action          (s_tuser),
        .pos_x           (s_tdata[C-1:0]),
        .pos_y           (s_tdata[2*C-1:C]),
        .pos_z           (s_tdata[3*C-1:2*C]),
        .size_w          (s_tdata[4*C-1:3*C]),
        .size_d          (s_tdata[5*C-1:4*C]),
        .size_h          (s_tdata[6*C-1:5*C]),
        .class_label     (s_tdata[6*C+CL-1:6*C]),
        .candidate_valid (s_tdata[6*C+CL]),
        .mode            (mode_reg),
        .out_valid       (f_valid),
        .out_ready       (f_ready),
        .out_rem         (f_rem),
        .out_uni         (f_uni),
        .out_side        (f_side)
    );

    // divider pipeline
    logic         d_valid, d_ready;
    logic [F-1:0] d_quot;
    side_t        d_side;

    bis_div #(.SW(SW), .F(F)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_rem    (f_rem),
        .in_uni    (f_uni),
        .in_side   (f_side),
        .out_valid (d_valid),
        .out_ready (d_ready),
        .out_quot  (d_quot),
        .out_side  (d_side)
    );

    // output stage: final iou and suppression decision
    logic         m_valid_reg;
    logic [F-1:0] iou_reg;
    logic         vo_reg, sup_reg;
    logic [F-1:0] iou_c;
    logic         hit_c;

    assign d_ready = !m_valid_reg || m_tready;

    always_comb
    begin
        if (d_side.zero)
            iou_c = '0;
        else if (d_side.sat)
            iou_c = '1;
        else
            iou_c = d_quot;
        hit_c = d_side.cvalid && d_side.cmatch && (CW'(iou_c) >= CW'(thr_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (d_ready)
            m_valid_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (d_ready)
        begin
            iou_reg <= iou_c;
            vo_reg  <= d_side.cvalid && !hit_c;
            sup_reg <= hit_c;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OTW'({sup_reg, vo_reg, iou_reg});

    // a cleared candidate is never reported valid
    a_sup_not_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && sup_reg |-> !vo_reg)
        else $error("suppressed item reported valid");

    // a clear only happens at or above the threshold
    a_sup_thr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && sup_reg |-> (CW'(iou_reg) >= CW'(thr_reg)))
        else $error("suppression below threshold");

    // input back-pressure only comes from a stalled output
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled with output free");

endmodule

[design/bis_front.sv]
// ----------------------------------------------------------------------------
// bis_front
// Edge build, reference store, overlap, intersection product and union.
// ----------------------------------------------------------------------------
module bis_front #(
    parameter int C  = 16,
    parameter int CL = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    action,
    input  logic [C-1:0]            pos_x,
    input  logic [C-1:0]            pos_y,
    input  logic [C-1:0]            pos_z,
    input  logic [C-1:0]            size_w,
    input  logic [C-1:0]            size_d,
    input  logic [C-1:0]            size_h,
    input  logic [CL-1:0]           class_label,
    input  logic                    candidate_valid,
    input  logic                    mode,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [3*C+3:0]          out_rem,
    output logic [3*C+3:0]          out_uni,
    output bis_pkg::side_t          out_side
);
    import bis_pkg::*;

    localparam int EW = C + 2;        // edge width, one extra fraction bit
    localparam int OW = C + 1;        // overlap width
    localparam int XW = 3 * C;        // extent width
    localparam int NW = 3 * C + 3;    // intersection width
    localparam int SW = 3 * C + 4;    // shifted sum width

    // reference box
    logic signed [EW-1:0] ref_lo_reg [3];
    logic signed [EW-1:0] ref_hi_reg [3];
    logic [XW-1:0]        ref_ext_reg;
    logic [CL-1:0]        ref_class_reg;

    // stage registers
    logic                 v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                 act1_reg, act2_reg;
    logic signed [EW-1:0] lo1_reg [3];
    logic signed [EW-1:0] hi1_reg [3];
    logic [2*C-1:0]       pwh1_reg, pwd1_reg;
    logic [C-1:0]         h1_reg;
    logic [CL-1:0]        cls1_reg;
    logic                 cv1_reg;
    logic [OW-1:0]        ov2_reg [3];
    logic                 pos2_reg, cm2_reg, cv2_reg;
    logic [XW-1:0]        ext2_reg;
    logic [2*OW-1:0]      p01_3_reg;
    logic [OW-1:0]        ovz3_reg;
    logic [SW-1:0]        sum3_reg, sum4_reg;
    side_t                side3_reg, side4_reg, side5_reg;
    logic [NW-1:0]        inter4_reg;
    logic [SW-1:0]        rem5_reg, uni5_reg;

    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    // ready chain, each stage takes an item when it is empty or moving on
    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // stage 1 inputs: edges and side products
    logic signed [EW-1:0] c2 [3];
    logic signed [EW-1:0] sx [3];
    logic signed [EW-1:0] lo_c [3];
    logic signed [EW-1:0] hi_c [3];
    logic [C-1:0]         s_y;

    always_comb
    begin
        s_y   = mode ? size_d : size_h;
        c2[0] = {pos_x[C-1], pos_x, 1'b0};
        c2[1] = {pos_y[C-1], pos_y, 1'b0};
        c2[2] = {pos_z[C-1], pos_z, 1'b0};
        sx[0] = {2'b00, size_w};
        sx[1] = {2'b00, s_y};
        sx[2] = {2'b00, size_h};
        for (int i = 0; i < 3; i++)
        begin
            lo_c[i] = c2[i] - sx[i];
            hi_c[i] = c2[i] + sx[i];
        end
        if (!mode)
        begin
            lo_c[2] = '0;
            hi_c[2] = '0;
        end
    end

    // stage 2 inputs: overlap per axis and box extent
    logic signed [EW-1:0] amax [3];
    logic signed [EW-1:0] bmin [3];
    logic signed [EW:0]   dif  [3];
    logic                 pos_c [3];
    logic [XW-1:0]        ext_c;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            amax[i]  = (lo1_reg[i] > ref_lo_reg[i]) ? lo1_reg[i] : ref_lo_reg[i];
            bmin[i]  = (hi1_reg[i] < ref_hi_reg[i]) ? hi1_reg[i] : ref_hi_reg[i];
            dif[i]   = {bmin[i][EW-1], bmin[i]} - {amax[i][EW-1], amax[i]};
            pos_c[i] = !dif[i][EW] && (dif[i] != '0);
        end
        if (mode)
            ext_c = {{C{1'b0}}, pwd1_reg} * {{(2*C){1'b0}}, h1_reg};
        else
            ext_c = {{C{1'b0}}, pwh1_reg};
    end

    // stage 3 inputs: sum of extents aligned to the intersection
    logic [SW-1:0] sum_raw, sum_c;

    always_comb
    begin
        sum_raw = SW'(ref_ext_reg) + SW'(ext2_reg);
        sum_c   = mode ? (sum_raw << 3) : (sum_raw << 2);
    end

    // stage 4 inputs: full intersection
    logic [NW-1:0] inter_c;

    always_comb
    begin
        if (mode)
            inter_c = {{OW{1'b0}}, p01_3_reg} * {{(2*OW){1'b0}}, ovz3_reg};
        else
            inter_c = NW'(p01_3_reg);
    end

    // stage 5 inputs: union and saturation
    logic [SW-1:0] inter_w, uni_c;
    side_t         side5_c;

    always_comb
    begin
        inter_w     = SW'(inter4_reg);
        uni_c       = sum4_reg - inter_w;
        side5_c     = side4_reg;
        side5_c.sat = (sum4_reg <= inter_w) || (uni_c <= inter_w);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg && (act2_reg == ACT_COMPARE);
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // reference store, edges leave stage 1 and extent leaves stage 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ref_lo_reg[i] <= '0;
                ref_hi_reg[i] <= '0;
            end
            ref_ext_reg   <= '0;
            ref_class_reg <= '0;
        end
        else
        begin
            if (v1_reg && rdy2 && (act1_reg == ACT_LOAD))
            begin
                for (int i = 0; i < 3; i++)
                begin
                    ref_lo_reg[i] <= lo1_reg[i];
                    ref_hi_reg[i] <= hi1_reg[i];
                end
                ref_class_reg <= cls1_reg;
            end
            if (v2_reg && rdy3 && (act2_reg == ACT_LOAD))
                ref_ext_reg <= ext2_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            act1_reg <= action;
            for (int i = 0; i < 3; i++)
            begin
                lo1_reg[i] <= lo_c[i];
                hi1_reg[i] <= hi_c[i];
            end
            pwh1_reg <= {{C{1'b0}}, size_w} * {{C{1'b0}}, size_h};
            pwd1_reg <= {{C{1'b0}}, size_w} * {{C{1'b0}}, size_d};
            h1_reg   <= size_h;
            cls1_reg <= class_label;
            cv1_reg  <= candidate_valid;
        end
        if (rdy2)
        begin
            act2_reg <= act1_reg;
            for (int i = 0; i < 3; i++)
                ov2_reg[i] <= dif[i][OW-1:0];
            pos2_reg <= pos_c[0] && pos_c[1] && (!mode || pos_c[2]);
            cm2_reg  <= (cls1_reg == ref_class_reg);
            cv2_reg  <= cv1_reg;
            ext2_reg <= ext_c;
        end
        if (rdy3)
        begin
            p01_3_reg        <= {{OW{1'b0}}, ov2_reg[0]} * {{OW{1'b0}}, ov2_reg[1]};
            ovz3_reg         <= ov2_reg[2];
            sum3_reg         <= sum_c;
            side3_reg.cvalid <= cv2_reg;
            side3_reg.cmatch <= cm2_reg;
            side3_reg.zero   <= !pos2_reg;
            side3_reg.sat    <= 1'b0;
        end
        if (rdy4)
        begin
            inter4_reg <= inter_c;
            sum4_reg   <= sum3_reg;
            side4_reg  <= side3_reg;
        end
        if (rdy5)
        begin
            rem5_reg  <= inter_w;
            uni5_reg  <= uni_c;
            side5_reg <= side5_c;
        end
    end

    assign out_valid = v5_reg;
    assign out_rem   = rem5_reg;
    assign out_uni   = uni5_reg;
    assign out_side  = side5_reg;

endmodule

[design/bis_div.sv]
// ----------------------------------------------------------------------------
// bis_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bis_div #(
    parameter int SW = 52,
    parameter int F  = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [SW-1:0]  in_rem,
    input  logic [SW-1:0]  in_uni,
    input  bis_pkg::side_t in_side,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [F-1:0]   out_quot,
    output bis_pkg::side_t out_side
);
    import bis_pkg::*;

    logic          dv_reg   [F];
    logic [SW-1:0] r_reg    [F];
    logic [SW-1:0] u_reg    [F];
    logic [F-1:0]  q_reg    [F];
    side_t         side_reg [F];

    logic          rdy  [F];
    logic          s_v  [F];
    logic [SW-1:0] s_r  [F];
    logic [SW-1:0] s_u  [F];
    logic [F-1:0]  s_q  [F];
    side_t         s_sd [F];
    logic [SW:0]   t    [F];
    logic [SW-1:0] nr   [F];
    logic [F-1:0]  nq   [F];

    // ready chain from the last stage back
    always_comb
    begin
        rdy[F-1] = !dv_reg[F-1] || out_ready;
        for (int k = F - 2; k >= 0; k--)
            rdy[k] = !dv_reg[k] || rdy[k+1];
    end

    // one shift, compare and subtract per stage
    always_comb
    begin
        for (int k = 0; k < F; k++)
        begin
            if (k == 0)
            begin
                s_v[k]  = in_valid;
                s_r[k]  = in_rem;
                s_u[k]  = in_uni;
                s_q[k]  = '0;
                s_sd[k] = in_side;
            end
            else
            begin
                s_v[k]  = dv_reg[k-1];
                s_r[k]  = r_reg[k-1];
                s_u[k]  = u_reg[k-1];
                s_q[k]  = q_reg[k-1];
                s_sd[k] = side_reg[k-1];
            end
            t[k] = {s_r[k], 1'b0};
            if (t[k] >= {1'b0, s_u[k]})
            begin
                nr[k] = SW'(t[k] - {1'b0, s_u[k]});
                nq[k] = {s_q[k][F-2:0], 1'b1};
            end
            else
            begin
                nr[k] = t[k][SW-1:0];
                nq[k] = {s_q[k][F-2:0], 1'b0};
            end
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < F; k++)
                dv_reg[k] <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < F; k++)
                if (rdy[k])
                    dv_reg[k] <= s_v[k];
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < F; k++)
        begin
            if (rdy[k])
            begin
                r_reg[k]    <= nr[k];
                u_reg[k]    <= s_u[k];
                q_reg[k]    <= nq[k];
                side_reg[k] <= s_sd[k];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = dv_reg[F-1];
    assign out_quot  = q_reg[F-1];
    assign out_side  = side_reg[F-1];

endmodule
